// ===== src/nmea_checksum_gga_satellite_count_defines.svh =====
// assertion macros for the sentence checker
`ifndef NMEA_CHECKSUM_GGA_SATELLITE_COUNT_DEFINES_SVH
`define NMEA_CHECKSUM_GGA_SATELLITE_COUNT_DEFINES_SVH

// clocked assertion with explicit clock and active-low reset
`define NMEA_GGA_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");

// clocked assertion on the usual clock and reset names
`define NMEA_GGA_ASSERT(label, prop) \
  `NMEA_GGA_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

// ===== src/nmea_gga_pkg.sv =====
package nmea_gga_pkg;

  localparam logic [7:0] CHR_DOLLAR = 8'h24;
  localparam logic [7:0] CHR_STAR   = 8'h2A;
  localparam logic [7:0] CHR_COMMA  = 8'h2C;
  localparam logic [7:0] CHR_ZERO   = 8'h30;
  localparam logic [7:0] CHR_NINE   = 8'h39;

  localparam logic [6:0] MAX_FIELD_LEN   = 7'd64;
  localparam logic [6:0] COUNT_LEN_LIMIT = 7'd6;
  localparam logic [6:0] FIELD_LEN_SAT   = 7'd127;
  localparam logic [3:0] FIX_FIELD       = 4'd6;
  localparam logic [3:0] COUNT_FIELD     = 4'd7;
  localparam logic [3:0] FIELD_IDX_SAT   = 4'd15;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_BODY = 2'd1,
    PH_HEX1 = 2'd2,
    PH_HEX2 = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    STAT_COUNT     = 2'd0,
    STAT_NOFIX     = 2'd1,
    STAT_MISMATCH  = 2'd2,
    STAT_MALFORMED = 2'd3
  } status_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] sat_count;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } res_item_t;

endpackage

// ===== src/nmea_gga_in_if.sv =====
interface nmea_gga_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== src/nmea_gga_out_if.sv =====
interface nmea_gga_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] sat_count;
  logic [7:0] computed_sum;
  logic [7:0] received_sum;

  modport source (
    output valid, output status, output sat_count, output computed_sum,
    output received_sum, input ready
  );
  modport sink (
    input valid, input status, input sat_count, input computed_sum,
    input received_sum, output ready
  );
endinterface

// ===== src/nmea_gga_in_stage.sv =====
module nmea_gga_in_stage import nmea_gga_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] rx_byte_i,
  output logic       ready_o,
  input  logic       out_free_i,
  output in_item_t   item_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       advance;
  logic       take;

  assign advance = valid_q && out_free_i;
  assign ready_o = !valid_q || advance;
  assign take    = valid_i && ready_o;
  assign valid_d = take || (valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= rx_byte_i;
    end
  end

  assign item_o.valid   = advance;
  assign item_o.rx_byte = byte_q;

endmodule

// ===== src/nmea_gga_parser.sv =====
module nmea_gga_parser import nmea_gga_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  item_i,
  output res_item_t res_o
);

  typedef struct packed {
    logic [3:0] nib;
    logic       bad;
  } hex_t;

  function automatic hex_t hex_dec(input logic [7:0] c);
    hex_t h;
    h.bad = 1'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.nib = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.nib = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.nib = 4'(c - 8'h37);
    end else begin
      h.nib = 4'd0;
      h.bad = 1'b1;
    end
    return h;
  endfunction

  phase_e     phase_q, phase_d;
  logic [7:0] xor_q, xor_d;
  logic [3:0] hi_nib_q, hi_nib_d;
  logic       hex_bad_q, hex_bad_d;
  logic [3:0] idx_q, idx_d;
  logic [6:0] len_q, len_d;
  status_e    outcome_q, outcome_d;
  logic       done_q, done_d;
  logic [7:0] accum_q, accum_d;
  logic       ended_q, ended_d;
  logic       lead_q, lead_d;
  logic [7:0] sats_q, sats_d;

  logic [7:0] c;
  logic       is_dollar, is_star, is_comma, is_digit;
  hex_t       hex;
  logic [7:0] rx_sum;
  logic       sum_bad;

  assign c         = item_i.rx_byte;
  assign is_dollar = (c == CHR_DOLLAR);
  assign is_star   = (c == CHR_STAR);
  assign is_comma  = (c == CHR_COMMA);
  assign is_digit  = (c >= CHR_ZERO) && (c <= CHR_NINE);
  assign hex       = hex_dec(c);
  assign rx_sum    = {hi_nib_q, hex.nib};
  assign sum_bad   = hex_bad_q || hex.bad || (rx_sum != xor_q);

  // phase sequencing
  always_comb begin
    phase_d = phase_q;
    if (item_i.valid) begin
      if (is_dollar) begin
        phase_d = PH_BODY;
      end else begin
        case (phase_q)
          PH_BODY: begin
            if (is_star) phase_d = PH_HEX1;
          end
          PH_HEX1: phase_d = PH_HEX2;
          PH_HEX2: phase_d = PH_HUNT;
          default: phase_d = phase_q;
        endcase
      end
    end
  end

  // sentence state and result
  always_comb begin
    xor_d     = xor_q;
    hi_nib_d  = hi_nib_q;
    hex_bad_d = hex_bad_q;
    idx_d     = idx_q;
    len_d     = len_q;
    outcome_d = outcome_q;
    done_d    = done_q;
    accum_d   = accum_q;
    ended_d   = ended_q;
    lead_d    = lead_q;
    sats_d    = sats_q;
    res_o.valid            = 1'b0;
    res_o.res.status       = STAT_MISMATCH;
    res_o.res.sat_count    = sats_q;
    res_o.res.computed_sum = xor_q;
    res_o.res.received_sum = rx_sum;
    if (item_i.valid) begin
      if (is_dollar) begin
        xor_d     = 8'd0;
        hi_nib_d  = 4'd0;
        hex_bad_d = 1'b0;
        idx_d     = 4'd0;
        len_d     = 7'd0;
        outcome_d = STAT_MALFORMED;
        done_d    = 1'b0;
        accum_d   = 8'd0;
        ended_d   = 1'b0;
        lead_d    = 1'b0;
      end else begin
        case (phase_q)
          PH_BODY: begin
            if (!is_star) xor_d = xor_q ^ c;
            if (!done_q) begin
              if (is_star || is_comma) begin
                if (len_q >= MAX_FIELD_LEN) begin
                  done_d    = 1'b1;
                  outcome_d = STAT_MALFORMED;
                end else if (idx_q == FIX_FIELD && len_q != 7'd0 && lead_q) begin
                  done_d    = 1'b1;
                  outcome_d = STAT_NOFIX;
                end else if (idx_q == COUNT_FIELD) begin
                  done_d    = 1'b1;
                  outcome_d = (len_q >= COUNT_LEN_LIMIT) ? STAT_MALFORMED : STAT_COUNT;
                end else if (is_star) begin
                  // star before any decision
                  done_d    = 1'b1;
                  outcome_d = STAT_MALFORMED;
                end else begin
                  if (idx_q != FIELD_IDX_SAT) idx_d = idx_q + 4'd1;
                  len_d   = 7'd0;
                  lead_d  = 1'b0;
                  accum_d = 8'd0;
                  ended_d = 1'b0;
                end
              end else begin
                if (len_q == 7'd0) lead_d = (c == CHR_ZERO);
                if (len_q != FIELD_LEN_SAT) len_d = len_q + 7'd1;
                if (idx_q == COUNT_FIELD && !ended_q) begin
                  if (is_digit) begin
                    accum_d = (accum_q << 3) + (accum_q << 1) + (c - CHR_ZERO);
                  end else begin
                    ended_d = 1'b1;
                  end
                end
              end
            end
          end
          PH_HEX1: begin
            hi_nib_d  = hex.nib;
            hex_bad_d = hex_bad_q || hex.bad;
          end
          PH_HEX2: begin
            hex_bad_d   = hex_bad_q || hex.bad;
            res_o.valid = 1'b1;
            if (sum_bad) begin
              res_o.res.status = STAT_MISMATCH;
            end else begin
              res_o.res.status = outcome_q;
              if (outcome_q == STAT_COUNT) begin
                sats_d = accum_q;
              end else if (outcome_q == STAT_NOFIX) begin
                sats_d = 8'd0;
              end
            end
            res_o.res.sat_count = sats_d;
          end
          default: begin
            xor_d = xor_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      xor_q     <= 8'd0;
      hi_nib_q  <= 4'd0;
      hex_bad_q <= 1'b0;
      idx_q     <= 4'd0;
      len_q     <= 7'd0;
      outcome_q <= STAT_MALFORMED;
      done_q    <= 1'b0;
      accum_q   <= 8'd0;
      ended_q   <= 1'b0;
      lead_q    <= 1'b0;
      sats_q    <= 8'd0;
    end else begin
      phase_q   <= phase_d;
      xor_q     <= xor_d;
      hi_nib_q  <= hi_nib_d;
      hex_bad_q <= hex_bad_d;
      idx_q     <= idx_d;
      len_q     <= len_d;
      outcome_q <= outcome_d;
      done_q    <= done_d;
      accum_q   <= accum_d;
      ended_q   <= ended_d;
      lead_q    <= lead_d;
      sats_q    <= sats_d;
    end
  end

endmodule

// ===== src/nmea_gga_out_stage.sv =====
module nmea_gga_out_stage import nmea_gga_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_item_t res_i,
  input  logic      ready_i,
  output logic      valid_o,
  output res_t      res_o,
  output logic      free_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = (valid_q && !ready_i) || res_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      res_q <= res_i.res;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== src/nmea_checksum_gga_satellite_count.sv =====
// NMEA 0183 sentence checker with satellite count extraction.
// in_i carries one received byte per transfer (rx_byte). A '$' opens a
// sentence; body bytes up to '*' are XORed and split into comma fields,
// and the two hex digits after '*' are compared with the XOR.
// out_o carries one result per sentence, after its second checksum
// digit: status, stored satellite count, computed and received checksum.
// Bytes that end no sentence give no result.
// A byte is taken into the input register, parsed as it leaves that register
// together with the sentence state, and its result is stored in the result
// register that drives out_o.
// Throughput: one byte per cycle while out_o is not stalled; the single
// pass of state update between the input and result registers sets the rate.
// Reset clears the parser to hunting for '$' with a stored count of zero,
// and empties both registers.
// When the receiver stalls, the result register holds and one more byte
// is kept in the input register; in_i.ready then drops until out_o moves.
module nmea_checksum_gga_satellite_count import nmea_gga_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  nmea_gga_in_if.sink    in_i,
  nmea_gga_out_if.source out_o
);

  in_item_t  item;
  res_item_t res_item;
  res_t      res;
  logic      out_free;

  nmea_gga_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_i.valid),
    .rx_byte_i  (in_i.rx_byte),
    .ready_o    (in_i.ready),
    .out_free_i (out_free),
    .item_o     (item)
  );

  nmea_gga_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .res_o  (res_item)
  );

  nmea_gga_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res_item),
    .ready_i (out_o.ready),
    .valid_o (out_o.valid),
    .res_o   (res),
    .free_o  (out_free)
  );

  assign out_o.status       = res.status;
  assign out_o.sat_count    = res.sat_count;
  assign out_o.computed_sum = res.computed_sum;
  assign out_o.received_sum = res.received_sum;

endmodule

// ===== src/nmea_gga_checker.sv =====
`include "nmea_checksum_gga_satellite_count_defines.svh"

module nmea_gga_checker import nmea_gga_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] status_i,
  input logic [7:0] sat_count_i,
  input logic [7:0] computed_sum_i,
  input logic [7:0] received_sum_i
);

  logic in_xfer;

  assign in_xfer = in_valid_i && in_ready_i;

  // stalled result holds
  `NMEA_GGA_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) && $stable(sat_count_i) && $stable(computed_sum_i) && $stable(received_sum_i))

  // a fresh result follows a byte transfer through the input and result registers
  `NMEA_GGA_ASSERT(a_res_latency, $rose(out_valid_i) |-> $past(in_xfer, 2))

  // input backpressure only from a stalled output
  `NMEA_GGA_ASSERT(a_ready_cause, !in_ready_i |-> out_valid_i && !out_ready_i)

  // no fix always leaves a zero count
  `NMEA_GGA_ASSERT(a_nofix_zero, out_valid_i && status_i == STAT_NOFIX |-> sat_count_i == 8'd0)

endmodule

bind nmea_checksum_gga_satellite_count nmea_gga_checker u_nmea_gga_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .status_i       (out_o.status),
  .sat_count_i    (out_o.sat_count),
  .computed_sum_i (out_o.computed_sum),
  .received_sum_i (out_o.received_sum)
);
